// ===== rtl/bsat_pkg.sv =====
// ----------------------------------------------------------------------------
// bsat_pkg
// Types, constants and helpers shared by the box separating axis test files.
// ----------------------------------------------------------------------------
package bsat_pkg;

  localparam int CoordFrac = 16;
  localparam int AxisFrac  = 14;
  localparam int ProjW     = 32 + 16 + 2;   // sum of three corner x axis products
  localparam int DepthW    = ProjW + 1;

  localparam logic [1:0] CMD_CORNER = 2'd0;
  localparam logic [1:0] CMD_AXIS   = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  localparam logic [28:0] TOL_RESET = 29'd268435;
  localparam logic [1:0]  REG_TOL   = 2'd0;

  typedef struct packed {
    logic [1:0]         command;
    logic               box_select;
    logic [2:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } item_t;

  typedef struct packed {
    logic               overlap;
    logic [30:0]        depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        test_count;
  } result_t;

  typedef logic signed [15:0] comp_t;
  typedef comp_t [2:0] vec_t;

  // clamp a signed value to 16 bits
  function automatic comp_t sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sd32767;
    end else if (v < -34'sd32768) begin
      return -16'sd32768;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== rtl/box_separating_axis_test.sv =====
// ----------------------------------------------------------------------------
// box_separating_axis_test
// Oriented box overlap test on 15 candidate axes, state in block memories.
// ----------------------------------------------------------------------------
// Corner and axis loads are written straight into the memories and busy stays
// low. A test holds busy through these steps:
// - axis memory reads in the FETCH state.
// - one cross product component per cycle.
// - per axis, a length check in the CHECK, LEN and TOL states, then 16 corner
//   reads through the corner memory port, a drain of the multiply/sum pipeline
//   and the interval compare in the EVAL state.
// A skipped axis goes through only the check states. The corner memory port
// sets the projection time. The result appears for one cycle with done high;
// the receiver cannot hold it, so it must take it then.
module box_separating_axis_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bsat_pkg::item_t      item,
  output logic                 busy,
  output logic                 done,
  output bsat_pkg::result_t    result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {
    IDLE, FETCH, CROSS, CHECK, LEN, TOL, PROJ, EVAL
  } state_t;

  state_t state;

  // configuration
  logic [28:0] tolerance;
  assign pready = 1'b1;
  assign prdata = (paddr == bsat_pkg::REG_TOL) ? {3'd0, tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= bsat_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && paddr == bsat_pkg::REG_TOL) begin
      tolerance <= pwdata[28:0];
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != IDLE);

  // memories
  logic [95:0] cmem [16];
  logic [95:0] cmem_q;
  logic [3:0]  cmem_raddr;
  logic [47:0] amem [6];
  logic [47:0] amem_q;
  logic [2:0]  amem_raddr;
  logic signed [15:0] ld_x, ld_y, ld_z;

  assign ld_x = bsat_pkg::sat16(34'(item.coord_x));
  assign ld_y = bsat_pkg::sat16(34'(item.coord_y));
  assign ld_z = bsat_pkg::sat16(34'(item.coord_z));

  always_ff @(posedge clk) begin
    if (accept && item.command == bsat_pkg::CMD_CORNER) begin
      cmem[{item.box_select, item.slot}] <= {item.coord_z, item.coord_y, item.coord_x};
    end
    cmem_q <= cmem[cmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == bsat_pkg::CMD_AXIS && item.slot < 3'd3) begin
      amem[item.box_select ? 3'(item.slot + 3'd3) : item.slot] <= {ld_z, ld_y, ld_x};
    end
    amem_q <= amem[amem_raddr];
  end

  // axis registers
  bsat_pkg::vec_t ax_a [3];
  bsat_pkg::vec_t ax_b [3];
  bsat_pkg::vec_t xr   [9];
  bsat_pkg::vec_t cand;
  bsat_pkg::vec_t cur;

  logic [4:0] step;
  logic [3:0] ai;
  logic [3:0] xi;
  logic [1:0] ci, cj, cc;
  logic [31:0] test_counter;

  assign amem_raddr = step[2:0];
  assign cmem_raddr = step[3:0];

  always_comb begin
    if (ai < 4'd3) begin
      cand = ax_a[ai[1:0]];
    end else if (ai < 4'd6) begin
      cand = ax_b[2'(ai - 4'd3)];
    end else begin
      cand = xr[4'(ai - 4'd6)];
    end
  end

  // cross product component
  bsat_pkg::vec_t xa, xb;
  logic [1:0] c1, c2;
  logic signed [31:0] xp1, xp2;
  logic signed [33:0] xv, xs;
  bsat_pkg::comp_t xcomp;

  assign xa = ax_a[ci];
  assign xb = ax_b[cj];
  always_comb begin
    case (cc)
      2'd0:    begin c1 = 2'd1; c2 = 2'd2; end
      2'd1:    begin c1 = 2'd2; c2 = 2'd0; end
      default: begin c1 = 2'd0; c2 = 2'd1; end
    endcase
  end
  assign xp1   = xa[c1] * xb[c2];
  assign xp2   = xa[c2] * xb[c1];
  assign xv    = 34'(xp1) - 34'(xp2) + (34'sd1 <<< (bsat_pkg::AxisFrac - 1));
  assign xs    = xv >>> bsat_pkg::AxisFrac;
  assign xcomp = bsat_pkg::sat16(xs);

  // squared length
  logic signed [33:0] len2, dev;
  logic [33:0] dev_abs;
  assign dev     = len2 - (34'sd1 <<< (2 * bsat_pkg::AxisFrac));
  assign dev_abs = dev[33] ? 34'(-dev) : 34'(dev);

  // projection pipeline
  logic v1, v2, v3;
  logic [3:0] idx1, idx2, idx3;
  logic signed [47:0] p0, p1, p2;
  logic signed [bsat_pkg::ProjW-1:0] psum;
  logic signed [bsat_pkg::ProjW-1:0] alo, ahi, blo, bhi;

  // interval compare
  logic signed [bsat_pkg::ProjW-1:0] mn_hi, mx_lo;
  logic signed [bsat_pkg::DepthW-1:0] d;
  logic separated;
  logic signed [bsat_pkg::DepthW-1:0] best;
  logic used;
  bsat_pkg::vec_t bn;
  logic flip;
  logic last_axis;
  logic [bsat_pkg::DepthW-bsat_pkg::AxisFrac-1:0] dq;

  assign mn_hi     = (ahi < bhi) ? ahi : bhi;
  assign mx_lo     = (alo > blo) ? alo : blo;
  assign d         = bsat_pkg::DepthW'(mn_hi) - bsat_pkg::DepthW'(mx_lo);
  assign separated = (blo > ahi) || (alo > bhi);
  assign flip      = blo < alo;
  assign last_axis = (ai == 4'd14);
  assign dq        = best[bsat_pkg::DepthW-1:bsat_pkg::AxisFrac];

  always_ff @(posedge clk) begin
    // projection datapath
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == PROJ) && (step < 5'd16);
      v2 <= v1;
      v3 <= v2;
    end
    idx1 <= step[3:0];
    idx2 <= idx1;
    p0   <= $signed(cmem_q[31:0])  * cur[0];
    p1   <= $signed(cmem_q[63:32]) * cur[1];
    p2   <= $signed(cmem_q[95:64]) * cur[2];
    idx3 <= idx2;
    psum <= bsat_pkg::ProjW'(p0) + bsat_pkg::ProjW'(p1) + bsat_pkg::ProjW'(p2);
    if (v3) begin
      if (!idx3[3]) begin
        if (idx3[2:0] == 3'd0 || psum < alo) alo <= psum;
        if (idx3[2:0] == 3'd0 || psum > ahi) ahi <= psum;
      end else begin
        if (idx3[2:0] == 3'd0 || psum < blo) blo <= psum;
        if (idx3[2:0] == 3'd0 || psum > bhi) bhi <= psum;
      end
    end
    len2 <= 34'(cur[0] * cur[0]) + 34'(cur[1] * cur[1]) + 34'(cur[2] * cur[2]);

    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      test_counter <= 32'd0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (accept && item.command == bsat_pkg::CMD_TEST) begin
            test_counter <= test_counter + 32'd1;
            state        <= FETCH;
            step         <= 5'd0;
            used         <= 1'b0;
            bn           <= '0;
          end
        end
        FETCH: begin
          if (step != 5'd0) begin
            if (step <= 5'd3) ax_a[2'(step - 5'd1)] <= amem_q;
            else              ax_b[2'(step - 5'd4)] <= amem_q;
          end
          step <= step + 5'd1;
          if (step == 5'd6) begin
            state <= CROSS;
            xi    <= 4'd0;
            ci    <= 2'd0;
            cj    <= 2'd0;
            cc    <= 2'd0;
          end
        end
        CROSS: begin
          xr[xi][cc] <= xcomp;
          if (cc != 2'd2) begin
            cc <= cc + 2'd1;
          end else begin
            cc <= 2'd0;
            xi <= xi + 4'd1;
            if (cj != 2'd2) begin
              cj <= cj + 2'd1;
            end else begin
              cj <= 2'd0;
              ci <= ci + 2'd1;
            end
            if (xi == 4'd8) begin
              state <= CHECK;
              ai    <= 4'd0;
            end
          end
        end
        CHECK: begin
          cur   <= cand;
          state <= LEN;
        end
        LEN: begin
          state <= TOL;
        end
        TOL: begin
          if (dev_abs > 34'(tolerance)) begin
            if (last_axis) begin
              state <= IDLE;
              done  <= 1'b1;
              result.overlap  <= 1'b1;
              result.depth    <= (!used || dq > 37'h7FFFFFFF) ? 31'h7FFFFFFF : dq[30:0];
              result.normal_x <= bn[0];
              result.normal_y <= bn[1];
              result.normal_z <= bn[2];
              result.test_count <= test_counter;
            end else begin
              ai    <= ai + 4'd1;
              state <= CHECK;
            end
          end else begin
            state <= PROJ;
            step  <= 5'd0;
          end
        end
        PROJ: begin
          if (step < 5'd16) step <= step + 5'd1;
          if (step == 5'd16 && !v1 && !v2 && !v3) state <= EVAL;
        end
        EVAL: begin
          if (separated) begin
            state <= IDLE;
            done  <= 1'b1;
            result <= '{overlap: 1'b0, depth: 31'd0, normal_x: 16'sd0, normal_y: 16'sd0,
                        normal_z: 16'sd0, test_count: test_counter};
          end else begin
            if (!used || d < best) begin
              used <= 1'b1;
              best <= d;
              bn[0] <= flip ? bsat_pkg::sat16(-34'(cur[0])) : cur[0];
              bn[1] <= flip ? bsat_pkg::sat16(-34'(cur[1])) : cur[1];
              bn[2] <= flip ? bsat_pkg::sat16(-34'(cur[2])) : cur[2];
            end
            if (last_axis) begin
              state <= IDLE;
              done  <= 1'b1;
              result.overlap <= 1'b1;
              if (!used || d < best) begin
                result.depth <= (d[bsat_pkg::DepthW-1:bsat_pkg::AxisFrac] > 37'h7FFFFFFF)
                                ? 31'h7FFFFFFF : d[bsat_pkg::AxisFrac+30:bsat_pkg::AxisFrac];
                result.normal_x <= flip ? bsat_pkg::sat16(-34'(cur[0])) : cur[0];
                result.normal_y <= flip ? bsat_pkg::sat16(-34'(cur[1])) : cur[1];
                result.normal_z <= flip ? bsat_pkg::sat16(-34'(cur[2])) : cur[2];
              end else begin
                result.depth    <= (dq > 37'h7FFFFFFF) ? 31'h7FFFFFFF : dq[30:0];
                result.normal_x <= bn[0];
                result.normal_y <= bn[1];
                result.normal_z <= bn[2];
              end
              result.test_count <= test_counter;
            end else begin
              ai    <= ai + 4'd1;
              state <= CHECK;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bsat_checker.sv =====
// ----------------------------------------------------------------------------
// bsat_checker
// Port level checks for the box separating axis test.
// ----------------------------------------------------------------------------
module bsat_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input bsat_pkg::item_t   item,
  input logic              busy,
  input logic              done,
  input bsat_pkg::result_t result
);

  // a test transfer always makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == bsat_pkg::CMD_TEST |=> busy)
    else $error("test not started");

  // a result only ends a busy test
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without test");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");

  // separated boxes report zero depth and a zero normal x component
  assert property (@(posedge clk) disable iff (rst)
    done && !result.overlap |-> result.depth == 31'd0 && result.normal_x == 16'sd0)
    else $error("separated result not cleared");

endmodule

bind box_separating_axis_test bsat_checker u_bsat_checker (
  .clk(clk), .rst(rst), .start(start), .item(item),
  .busy(busy), .done(done), .result(result)
);
